// ----- design/asps_pkg.sv -----
// asps_pkg: shared types and constants of the air sensor poll sequencer
// no dependencies; used by asps_step, air_sensor_poll_sequencer, asps_checker and tb

package asps_pkg;

	// bus command kind
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic CFG_MEASURE_MODE   = 1'b1;
	localparam logic [7:0] MEASURE_MODE_RESET = 8'h20;

	// sensor register indexes and command bytes
	localparam logic [7:0] REG_STATUS     = 8'h00;
	localparam logic [7:0] REG_MEAS_MODE  = 8'h01;
	localparam logic [7:0] REG_ALG_RESULT = 8'h02;
	localparam logic [7:0] REG_ENV_DATA   = 8'h05;
	localparam logic [7:0] REG_FW_APP_VER = 8'h24;
	localparam logic [7:0] REG_ERROR_ID   = 8'hE0;
	localparam logic [7:0] CMD_APP_START  = 8'hF4;
	localparam logic [7:0] CMD_SW_RESET   = 8'hFF;

	// status byte decode
	localparam logic [7:0] STATUS_MASK      = 8'h99;
	localparam logic [7:0] STATUS_NO_DATA   = 8'h90;
	localparam logic [7:0] STATUS_DATA_RDY  = 8'h98;
	localparam logic [7:0] BOOT_MASK        = 8'h81;
	localparam logic [7:0] ERROR_BIT        = 8'h01;
	localparam logic [7:0] ERROR_STUCK      = 8'hFF;

	// temperature offset of 25 degrees in q9
	localparam logic signed [17:0] TEMP_OFFSET_Q9 = 18'sd12800;

	localparam int IN_BITS  = 68;
	localparam int OUT_BITS = 98;
	localparam int IN_BYTES_BITS  = 72;
	localparam int OUT_BYTES_BITS = 104;

	typedef struct packed {
		logic signed [16:0] temperature_q9;
		logic [15:0]        humidity_q9;
		logic [31:0]        rx_data;
		logic [2:0]         rx_count;
	} item_t;

	typedef struct packed {
		logic [15:0] firmware_version;
		logic [15:0] tvoc_ppb;
		logic [15:0] eco2_ppm;
		logic        wake_pin_setup;
		logic        yield_flag;
		logic [2:0]  read_length;
		logic [39:0] write_bytes;
		logic [2:0]  write_length;
		kind_t       txn_kind;
	} result_t;

endpackage

// ----- design/asps_step.sv -----
// asps_step: sequencer state, latched readings and the per-tick command decode
// depends on asps_pkg

module asps_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  asps_pkg::item_t    item,
	input  logic [7:0]         mode_byte,
	output asps_pkg::result_t  result
);

	typedef enum logic [3:0] {
		ST_SLEEP_END       = 4'd0,
		ST_APP_START       = 4'd1,
		ST_MODE_WRITE      = 4'd2,
		ST_SELECT_STATUS   = 4'd3,
		ST_START_RD_STATUS = 4'd4,
		ST_RD_STATUS       = 4'd5,
		ST_START_RD_MEAS   = 4'd6,
		ST_RD_MEAS         = 4'd7,
		ST_START_RD_FW     = 4'd8,
		ST_RD_FW           = 4'd9,
		ST_START_RD_ERR    = 4'd10,
		ST_RD_ERR          = 4'd11,
		ST_SWRESET         = 4'd12
	} state_t;

	state_t      state_q, state_nx;
	logic [15:0] fw_q, fw_nx;
	logic [15:0] eco2_q, eco2_nx;
	logic [15:0] tvoc_q, tvoc_nx;

	logic [7:0]         b0, b1;
	logic signed [17:0] temp_sum;
	logic [15:0]        temp_word;

	assign b0 = item.rx_data[31:24];
	assign b1 = item.rx_data[23:16];
	assign temp_sum = 18'(item.temperature_q9) + asps_pkg::TEMP_OFFSET_Q9;

	// clamp to 0..65535
	always_comb begin
		if (temp_sum < 0) begin
			temp_word = 16'h0000;
		end else if (temp_sum[17:16] != 2'b00) begin
			temp_word = 16'hFFFF;
		end else begin
			temp_word = temp_sum[15:0];
		end
	end

	always_comb begin
		state_nx = state_q;
		fw_nx    = fw_q;
		eco2_nx  = eco2_q;
		tvoc_nx  = tvoc_q;
		result.txn_kind       = asps_pkg::KIND_NONE;
		result.write_length   = 3'd0;
		result.write_bytes    = 40'd0;
		result.read_length    = 3'd0;
		result.yield_flag     = 1'b1;
		result.wake_pin_setup = 1'b0;
		case (state_q)
			ST_SLEEP_END: begin
				result.wake_pin_setup = 1'b1;
				result.yield_flag     = 1'b0;
				state_nx = ST_SELECT_STATUS;
			end
			ST_APP_START: begin
				result.txn_kind     = asps_pkg::KIND_WRITE;
				result.write_length = 3'd1;
				result.write_bytes  = {asps_pkg::CMD_APP_START, 32'd0};
				state_nx = ST_MODE_WRITE;
			end
			ST_MODE_WRITE: begin
				result.txn_kind     = asps_pkg::KIND_WRITE;
				result.write_length = 3'd2;
				result.write_bytes  = {asps_pkg::REG_MEAS_MODE, mode_byte, 24'd0};
				result.yield_flag   = 1'b0;
				state_nx = ST_SELECT_STATUS;
			end
			ST_SWRESET: begin
				result.txn_kind     = asps_pkg::KIND_WRITE;
				result.write_length = 3'd1;
				result.write_bytes  = {asps_pkg::CMD_SW_RESET, 32'd0};
				result.yield_flag   = 1'b0;
				state_nx = ST_SELECT_STATUS;
			end
			ST_SELECT_STATUS: begin
				result.txn_kind     = asps_pkg::KIND_WRITE;
				result.write_length = 3'd1;
				result.write_bytes  = {asps_pkg::REG_STATUS, 32'd0};
				state_nx = ST_START_RD_STATUS;
			end
			ST_START_RD_STATUS: begin
				result.txn_kind    = asps_pkg::KIND_READ;
				result.read_length = 3'd1;
				result.yield_flag  = 1'b0;
				state_nx = ST_RD_STATUS;
			end
			ST_RD_STATUS: begin
				// not a one-byte read: no command, stay
				if (item.rx_count == 3'd1) begin
					if ((b0 & asps_pkg::STATUS_MASK) == asps_pkg::STATUS_NO_DATA) begin
						result.txn_kind     = asps_pkg::KIND_WRITE;
						result.write_length = 3'd1;
						if (fw_q[15:8] == 8'd0) begin
							result.write_bytes = {asps_pkg::REG_FW_APP_VER, 32'd0};
							state_nx = ST_START_RD_FW;
						end else begin
							result.write_bytes = {asps_pkg::REG_STATUS, 32'd0};
							state_nx = ST_START_RD_STATUS;
						end
					end else if ((b0 & asps_pkg::STATUS_MASK) == asps_pkg::STATUS_DATA_RDY) begin
						result.txn_kind     = asps_pkg::KIND_WRITE;
						result.write_length = 3'd1;
						result.write_bytes  = {asps_pkg::REG_ALG_RESULT, 32'd0};
						state_nx = ST_START_RD_MEAS;
					end else if ((b0 & asps_pkg::BOOT_MASK) == 8'd0) begin
						result.txn_kind     = asps_pkg::KIND_WRITE;
						result.write_length = 3'd1;
						result.write_bytes  = {asps_pkg::CMD_APP_START, 32'd0};
						state_nx = ST_MODE_WRITE;
					end else if ((b0 & asps_pkg::ERROR_BIT) == asps_pkg::ERROR_BIT) begin
						result.txn_kind     = asps_pkg::KIND_WRITE;
						result.write_length = 3'd1;
						result.write_bytes  = {asps_pkg::REG_ERROR_ID, 32'd0};
						state_nx = ST_START_RD_ERR;
					end else begin
						state_nx = ST_SWRESET;
					end
				end
			end
			ST_START_RD_FW: begin
				result.txn_kind    = asps_pkg::KIND_READ;
				result.read_length = 3'd2;
				state_nx = ST_RD_FW;
			end
			ST_RD_FW: begin
				if (item.rx_count >= 3'd1) begin
					fw_nx[15:8] = b0;
				end
				if (item.rx_count >= 3'd2) begin
					fw_nx[7:0] = b1;
				end
				state_nx = ST_START_RD_STATUS;
			end
			ST_START_RD_ERR: begin
				result.txn_kind    = asps_pkg::KIND_READ;
				result.read_length = 3'd1;
				state_nx = ST_RD_ERR;
			end
			ST_RD_ERR: begin
				// an error id of all ones keeps the sequencer here
				if (item.rx_count == 3'd0 || b0 != asps_pkg::ERROR_STUCK) begin
					state_nx = ST_SWRESET;
				end
			end
			ST_START_RD_MEAS: begin
				result.txn_kind    = asps_pkg::KIND_READ;
				result.read_length = 3'd4;
				result.yield_flag  = 1'b0;
				state_nx = ST_RD_MEAS;
			end
			default: begin
				// read meas, also taken by unused codes
				if (item.rx_count == 3'd4) begin
					eco2_nx = item.rx_data[31:16];
					tvoc_nx = item.rx_data[15:0];
				end
				result.txn_kind     = asps_pkg::KIND_WRITE;
				result.write_length = 3'd5;
				result.write_bytes  = {asps_pkg::REG_ENV_DATA, item.humidity_q9, temp_word};
				state_nx = ST_SELECT_STATUS;
			end
		endcase
		result.eco2_ppm         = eco2_nx;
		result.tvoc_ppb         = tvoc_nx;
		result.firmware_version = fw_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SLEEP_END;
			fw_q    <= 16'd0;
			eco2_q  <= 16'd0;
			tvoc_q  <= 16'd0;
		end else if (fire) begin
			state_q <= state_nx;
			fw_q    <= fw_nx;
			eco2_q  <= eco2_nx;
			tvoc_q  <= tvoc_nx;
		end
	end

	// sleep end is only left, never re-entered
	a_no_sleep_return: assert property (@(posedge clk) disable iff (!arst_n)
		fire && state_q != ST_SLEEP_END |=> state_q != ST_SLEEP_END)
		else $error("sequencer returned to sleep end");

	// the wake pulse comes with no bus command
	a_wake_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result.wake_pin_setup |-> result.txn_kind == asps_pkg::KIND_NONE)
		else $error("wake pulse with a bus command");

	// readings only change on a tick
	a_latch_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(eco2_q) && $stable(tvoc_q) && $stable(fw_q))
		else $error("latched reading changed without a tick");

endmodule

// ----- design/air_sensor_poll_sequencer.sv -----
// air_sensor_poll_sequencer: top level with input register, step logic and result register
// depends on asps_pkg and asps_step
// a tick accepted into the input register moves on to the result register, which drives
//   the command; throughput one tick per cycle while m_tready does not stall the output
// the sequencer state is read and updated as the tick leaves the input register
// reset (arst_n low): sequencer at sleep end, readings and firmware version zero,
//   mode byte 0x20, both pipeline stages empty

module air_sensor_poll_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	// poll tick input
	input  logic         s_tvalid,
	output logic         s_tready,
	// rx_count[2:0], rx_data[34:3], humidity_q9[50:35], temperature_q9[67:51], zero fill
	input  logic [71:0]  s_tdata,
	// command output
	output logic         m_tvalid,
	input  logic         m_tready,
	// txn_kind[1:0], write_length[4:2], write_bytes[44:5], read_length[47:45],
	// yield_flag[48], wake_pin_setup[49], eco2_ppm[65:50], tvoc_ppb[81:66],
	// firmware_version[97:82], zero fill
	output logic [103:0] m_tdata
);

	// drive mode byte; the device address has no result field and is not held
	logic [7:0] mode_byte_q;

	// input stage
	logic            valid_s1;
	asps_pkg::item_t item_s1;

	// result stage
	logic              out_valid_q;
	asps_pkg::result_t res_q;
	asps_pkg::result_t res_nx;

	logic fire;      // tick moves from input stage into result register
	logic in_take;   // input transaction

	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign in_take  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_byte_q <= asps_pkg::MEASURE_MODE_RESET;
		end else if (cfg_we && cfg_index == asps_pkg::CFG_MEASURE_MODE) begin
			mode_byte_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= s_tdata[asps_pkg::IN_BITS-1:0];
		end
	end

	asps_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.mode_byte (mode_byte_q),
		.result    (res_nx)
	);

	// result register, loads whenever it is empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(asps_pkg::OUT_BYTES_BITS - asps_pkg::OUT_BITS){1'b0}}, res_q};

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !fire)
		else $error("result register overwritten while stalled");

	// lengths and bytes only go with their command kind
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |->
			(res_q.txn_kind == asps_pkg::KIND_WRITE ||
				(res_q.write_length == 3'd0 && res_q.write_bytes == 40'd0)) &&
			(res_q.txn_kind == asps_pkg::KIND_READ || res_q.read_length == 3'd0))
		else $error("command fields do not match command kind");

	// a held tick is not lost from the input stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1)
		else $error("input stage dropped a tick");

endmodule

// ----- verif/asps_checker.sv -----
// asps_checker: watches the tick, command and configuration ports of the poll sequencer,
// predicts every command and compares it field by field; depends on asps_pkg only

module asps_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [71:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	output int           errors,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		SQ_SLEEP_END       = 4'd0,
		SQ_APP_START       = 4'd1,
		SQ_MODE_WRITE      = 4'd2,
		SQ_SELECT_STATUS   = 4'd3,
		SQ_START_RD_STATUS = 4'd4,
		SQ_RD_STATUS       = 4'd5,
		SQ_START_RD_MEAS   = 4'd6,
		SQ_RD_MEAS         = 4'd7,
		SQ_START_RD_FW     = 4'd8,
		SQ_RD_FW           = 4'd9,
		SQ_START_RD_ERR    = 4'd10,
		SQ_RD_ERR          = 4'd11,
		SQ_SW_RESET        = 4'd12
	} poll_state_t;

	poll_state_t         poll_state;
	logic [15:0]         fw_word;
	logic [15:0]         eco2_word;
	logic [15:0]         tvoc_word;
	logic [7:0]          mode_byte;
	asps_pkg::result_t   command_q[$];
	int                  fail_count = 0;
	int                  command_idx = 0;

	assign errors = fail_count;

	function automatic asps_pkg::result_t with_write(asps_pkg::result_t r, int n,
			logic [39:0] payload);
		r.txn_kind     = asps_pkg::KIND_WRITE;
		r.write_length = 3'(n);
		r.write_bytes  = payload << (8 * (5 - n));
		return r;
	endfunction

	function automatic asps_pkg::result_t with_read(asps_pkg::result_t r, int n);
		r.txn_kind    = asps_pkg::KIND_READ;
		r.read_length = 3'(n);
		return r;
	endfunction

	// one poll tick: command for this tick, state and latched readings updated
	function automatic asps_pkg::result_t poll_step(asps_pkg::item_t t);
		asps_pkg::result_t r;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] err_byte;
		logic signed [17:0] t_shift;
		logic [15:0] t_word;
		r = '0;
		r.yield_flag = 1'b1;
		b0 = t.rx_data[31:24];
		b1 = t.rx_data[23:16];
		case (poll_state)
		SQ_SLEEP_END: begin
			r.wake_pin_setup = 1'b1;
			r.yield_flag = 1'b0;
			poll_state = SQ_SELECT_STATUS;
		end
		SQ_APP_START: begin
			r = with_write(r, 1, 40'(asps_pkg::CMD_APP_START));
			poll_state = SQ_MODE_WRITE;
		end
		SQ_MODE_WRITE: begin
			r = with_write(r, 2, 40'({asps_pkg::REG_MEAS_MODE, mode_byte}));
			r.yield_flag = 1'b0;
			poll_state = SQ_SELECT_STATUS;
		end
		SQ_SW_RESET: begin
			r = with_write(r, 1, 40'(asps_pkg::CMD_SW_RESET));
			r.yield_flag = 1'b0;
			poll_state = SQ_SELECT_STATUS;
		end
		SQ_SELECT_STATUS: begin
			r = with_write(r, 1, 40'(asps_pkg::REG_STATUS));
			poll_state = SQ_START_RD_STATUS;
		end
		SQ_START_RD_STATUS: begin
			r = with_read(r, 1);
			r.yield_flag = 1'b0;
			poll_state = SQ_RD_STATUS;
		end
		SQ_RD_STATUS: begin
			// a status read of other than one byte leaves everything as it is
			if (t.rx_count == 3'd1) begin
				if ((b0 & asps_pkg::STATUS_MASK) == asps_pkg::STATUS_NO_DATA) begin
					if (fw_word[15:8] == 8'h00) begin
						r = with_write(r, 1, 40'(asps_pkg::REG_FW_APP_VER));
						poll_state = SQ_START_RD_FW;
					end else begin
						r = with_write(r, 1, 40'(asps_pkg::REG_STATUS));
						poll_state = SQ_START_RD_STATUS;
					end
				end else if ((b0 & asps_pkg::STATUS_MASK) == asps_pkg::STATUS_DATA_RDY) begin
					r = with_write(r, 1, 40'(asps_pkg::REG_ALG_RESULT));
					poll_state = SQ_START_RD_MEAS;
				end else if ((b0 & asps_pkg::BOOT_MASK) == 8'h00) begin
					r = with_write(r, 1, 40'(asps_pkg::CMD_APP_START));
					poll_state = SQ_MODE_WRITE;
				end else if ((b0 & asps_pkg::ERROR_BIT) != 8'h00) begin
					r = with_write(r, 1, 40'(asps_pkg::REG_ERROR_ID));
					poll_state = SQ_START_RD_ERR;
				end else begin
					poll_state = SQ_SW_RESET;
				end
			end
		end
		SQ_START_RD_FW: begin
			r = with_read(r, 2);
			poll_state = SQ_RD_FW;
		end
		SQ_RD_FW: begin
			if (t.rx_count >= 3'd1)
				fw_word[15:8] = b0;
			if (t.rx_count >= 3'd2)
				fw_word[7:0] = b1;
			poll_state = SQ_START_RD_STATUS;
		end
		SQ_START_RD_ERR: begin
			r = with_read(r, 1);
			poll_state = SQ_RD_ERR;
		end
		SQ_RD_ERR: begin
			// an error byte of all ones keeps it here
			err_byte = (t.rx_count >= 3'd1) ? b0 : 8'h00;
			if (err_byte != asps_pkg::ERROR_STUCK)
				poll_state = SQ_SW_RESET;
		end
		SQ_START_RD_MEAS: begin
			r = with_read(r, 4);
			r.yield_flag = 1'b0;
			poll_state = SQ_RD_MEAS;
		end
		default: begin
			if (t.rx_count == 3'd4) begin
				eco2_word = t.rx_data[31:16];
				tvoc_word = t.rx_data[15:0];
			end
			t_shift = $signed(t.temperature_q9);
			t_shift = t_shift + asps_pkg::TEMP_OFFSET_Q9;
			if (t_shift < 0)
				t_word = 16'h0000;
			else if (t_shift > 18'sd65535)
				t_word = 16'hFFFF;
			else
				t_word = t_shift[15:0];
			r = with_write(r, 5, {asps_pkg::REG_ENV_DATA, t.humidity_q9, t_word});
			poll_state = SQ_SELECT_STATUS;
		end
		endcase
		r.eco2_ppm = eco2_word;
		r.tvoc_ppb = tvoc_word;
		r.firmware_version = fw_word;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [39:0] got, logic [39:0] want);
		if (got !== want)
			report_mismatch($sformatf("command %0d %s got %0h want %0h",
				command_idx, name, got, want));
	endtask

	task automatic compare_command(asps_pkg::result_t got);
		asps_pkg::result_t want;
		if (command_q.size() == 0) begin
			report_mismatch($sformatf("command %0d with none expected: %h", command_idx, got));
			command_idx++;
			return;
		end
		want = command_q.pop_front();
		check_field("txn_kind", 40'(got.txn_kind), 40'(want.txn_kind));
		check_field("write_length", 40'(got.write_length), 40'(want.write_length));
		check_field("write_bytes", got.write_bytes, want.write_bytes);
		check_field("read_length", 40'(got.read_length), 40'(want.read_length));
		check_field("yield_flag", 40'(got.yield_flag), 40'(want.yield_flag));
		check_field("wake_pin_setup", 40'(got.wake_pin_setup), 40'(want.wake_pin_setup));
		check_field("eco2_ppm", 40'(got.eco2_ppm), 40'(want.eco2_ppm));
		check_field("tvoc_ppb", 40'(got.tvoc_ppb), 40'(want.tvoc_ppb));
		check_field("firmware_version", 40'(got.firmware_version),
			40'(want.firmware_version));
		command_idx++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_state = SQ_SLEEP_END;
			fw_word = '0;
			eco2_word = '0;
			tvoc_word = '0;
			mode_byte = asps_pkg::MEASURE_MODE_RESET;
			command_q.delete();
			pending <= 0;
		end else begin
			// the device address reaches no command field, so only the mode byte is kept
			if (cfg_we && cfg_index == asps_pkg::CFG_MEASURE_MODE)
				mode_byte = cfg_data;
			if (m_tvalid && m_tready)
				compare_command(m_tdata[asps_pkg::OUT_BITS-1:0]);
			if (s_tvalid && s_tready)
				command_q.push_back(poll_step(s_tdata[asps_pkg::IN_BITS-1:0]));
			pending <= command_q.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// tb: stimulus and verdict for the air sensor poll sequencer
// depends on asps_pkg, air_sensor_poll_sequencer and asps_checker

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [7:0]   cfg_data = 8'h00;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;

	int fail_total;
	int cmds_pending;

	// idle rates in percent; the sink rate and the hold request are read by the
	// sink process at the same edges, so they change by nonblocking assignment
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always #5 clk = ~clk;

	air_sensor_poll_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	asps_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (fail_total),
		.pending  (cmds_pending)
	);

	// command sink: random stalls, plus a long hold-off on request that is
	// counted here so the two pipeline stages fill and the tick input backs up
	always @(posedge clk) begin
		if (hold_left == 0 && hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 60;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// every task below starts and ends at a rising edge with nothing scheduled
	// in that step except what it drives itself

	// register write: enable high for exactly one edge
	task automatic cfg_write(logic idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// offer one tick, idling cycle by cycle at the sender rate first,
	// and return at the edge that takes it
	task automatic send_tick(asps_pkg::item_t t);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(asps_pkg::IN_BYTES_BITS - asps_pkg::IN_BITS){1'b0}}, t};
		do @(posedge clk); while (!s_tready);
	endtask

	// the checker count is registered, so read it only from the edge after the last transaction
	task automatic wait_drained();
		@(posedge clk);
		while (cmds_pending != 0)
			@(posedge clk);
	endtask

	function automatic asps_pkg::item_t make_tick(int count, logic [31:0] data, int hum,
			int temp);
		asps_pkg::item_t t;
		t.rx_count = count[2:0];
		t.rx_data = data;
		t.humidity_q9 = hum[15:0];
		t.temperature_q9 = temp[16:0];
		return t;
	endfunction

	// ticks shaped to walk the sequencer: one-byte status reads most often, with a
	// status byte from each decode class, four-byte reads for measurements
	function automatic asps_pkg::item_t random_tick();
		asps_pkg::item_t t;
		int pick;
		int hum;
		int temp;
		logic [7:0] b0;
		logic [7:0] noise;
		noise = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 45)
			t.rx_count = 3'd1;
		else if (pick < 70)
			t.rx_count = 3'd4;
		else if (pick < 80)
			t.rx_count = 3'd2;
		else if (pick < 90)
			t.rx_count = 3'd0;
		else
			t.rx_count = 3'd3;

		pick = $urandom_range(99);
		if (pick < 25)
			b0 = asps_pkg::STATUS_NO_DATA | (noise & ~asps_pkg::STATUS_MASK);   // no data
		else if (pick < 55)
			b0 = asps_pkg::STATUS_DATA_RDY | (noise & ~asps_pkg::STATUS_MASK);  // data ready
		else if (pick < 65)
			b0 = noise & ~asps_pkg::BOOT_MASK;                                  // boot mode
		else if (pick < 75)
			b0 = noise | asps_pkg::ERROR_BIT;                                   // error flagged
		else if (pick < 85)
			b0 = (noise & 8'h6E) | 8'h80;                    // abnormal, leads to reset
		else if (pick < 90)
			b0 = asps_pkg::ERROR_STUCK;
		else
			b0 = 8'($urandom);
		t.rx_data = {b0, 24'($urandom)};
		if ($urandom_range(19) == 0)
			t.rx_data = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;

		case ($urandom_range(9))
		0: hum = 0;
		1: hum = 51200;
		default: hum = $urandom_range(51200);
		endcase

		// saturation edges of the offset temperature word now and then
		case ($urandom_range(15))
		0: temp = -20480;
		1: temp = 64000;
		2: temp = -12800;
		3: temp = -12801;
		4: temp = 52735;
		5: temp = 52736;
		6: temp = -1;
		default: temp = $urandom_range(84480) - 20480;
		endcase
		t.humidity_q9 = hum[15:0];
		t.temperature_q9 = temp[16:0];
		return t;
	endfunction

	// one stretch of random ticks at one setting, drained before returning
	task automatic run_phase(int src_pct, int sink_pct, logic [6:0] addr,
			logic [7:0] mode, int count, bit with_hold);
		cfg_write(asps_pkg::CFG_DEVICE_ADDRESS, {1'b0, addr});
		cfg_write(asps_pkg::CFG_MEASURE_MODE, mode);
		src_idle_pct = src_pct;
		sink_idle_pct <= sink_pct;
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 3)
				hold_req <= hold_req + 1;
			send_tick(random_tick());
		end
		s_tvalid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk through every reachable sequencer state, register extremes first
		cfg_write(asps_pkg::CFG_DEVICE_ADDRESS, 8'h7F);
		cfg_write(asps_pkg::CFG_MEASURE_MODE, 8'hFF);
		src_idle_pct = 19;
		sink_idle_pct <= 69;
		send_tick(random_tick());                                // wake from sleep
		send_tick(random_tick());                                // select status
		send_tick(random_tick());                                // start status read
		send_tick(make_tick(0, 32'h9000_0000, 0, 0));            // short status read, no move
		send_tick(make_tick(1, 32'h90FF_FFFF, 0, 0));            // no data, version unknown
		send_tick(random_tick());                                // start firmware read
		send_tick(make_tick(1, 32'h12AB_0000, 0, 0));            // only the high byte arrives
		send_tick(random_tick());                                // start status read
		send_tick(make_tick(1, 32'hF600_0000, 0, 0));            // no data, version known
		send_tick(random_tick());                                // start status read
		send_tick(make_tick(1, 32'h9800_0000, 0, 0));            // data ready
		send_tick(random_tick());                                // start measurement read
		send_tick(make_tick(4, 32'hFFFF_0000, 0, -20480));       // latch, temperature floor
		send_tick(random_tick());                                // select status
		send_tick(random_tick());                                // start status read
		send_tick(make_tick(1, 32'h0000_0000, 51200, 64000));    // boot mode, app start
		send_tick(random_tick());                                // mode write
		send_tick(random_tick());                                // select status
		send_tick(random_tick());                                // start status read
		send_tick(make_tick(1, 32'h0100_0000, 0, 0));            // error bit set
		send_tick(random_tick());                                // start error read
		send_tick(make_tick(1, 32'hFFFF_FFFF, 0, 0));            // stuck error byte
		send_tick(make_tick(0, 32'hFFFF_FFFF, 0, 0));            // empty error read, reset
		send_tick(random_tick());                                // software reset
		send_tick(random_tick());                                // select status
		send_tick(random_tick());                                // start status read
		send_tick(make_tick(1, 32'h8000_0000, 0, 0));            // abnormal status
		s_tvalid <= 1'b0;
		wait_drained();

		// random part: sender idles lightly, then the sink does, then nobody;
		// the last phase also holds the sink off while ticks keep coming
		run_phase(19, 69, 7'h00, 8'h00, 180, 1'b0);
		run_phase(69, 19, 7'($urandom), 8'($urandom), 180, 1'b0);
		run_phase(0, 0, 7'h5A, 8'hA5, 190, 1'b1);

		// catch any stray command after the last expected one
		repeat (10) @(posedge clk);
		if (fail_total == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// far beyond the slowest correct run
	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/asps_pkg.sv
design/asps_step.sv
design/air_sensor_poll_sequencer.sv
verif/asps_checker.sv
verif/tb.sv
